// ===== src/owts_pkg.sv =====
package owts_pkg;

  localparam int unsigned TIMER_W = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] CMD_SKIP     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_SLOT_START    = 3'd3,
    REG_WRITE_SLOT    = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_READ_RECOVER  = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    STG_RESET_CONV = 4'd0,
    STG_SKIP_CONV  = 4'd1,
    STG_CONVERT    = 4'd2,
    STG_POLL       = 4'd3,
    STG_RESET_READ = 4'd4,
    STG_SKIP_READ  = 4'd5,
    STG_READ_PAD   = 4'd6,
    STG_READ_LOW   = 4'd7,
    STG_READ_HIGH  = 4'd8,
    STG_RESET_LAST = 4'd9
  } stage_t;

  typedef enum logic [1:0] {
    SUB_OPEN   = 2'd0,
    SUB_MIDDLE = 2'd1,
    SUB_TAIL   = 2'd2
  } sub_t;

  typedef enum logic [1:0] {
    KIND_RESET = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  function automatic kind_t stage_kind(input stage_t stage);
    kind_t k;
    unique case (stage)
      STG_RESET_CONV, STG_RESET_READ, STG_RESET_LAST: k = KIND_RESET;
      STG_POLL, STG_READ_LOW, STG_READ_HIGH:          k = KIND_READ;
      default:                                        k = KIND_WRITE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] stage_cmd(input stage_t stage);
    logic [7:0] c;
    unique case (stage)
      STG_CONVERT:                  c = CMD_CONVERT;
      STG_READ_PAD:                 c = CMD_READ_PAD;
      STG_SKIP_CONV, STG_SKIP_READ: c = CMD_SKIP;
      default:                      c = 8'h00;
    endcase
    return c;
  endfunction

  // nibble * 625 / 100 is nibble * 25 / 4
  function automatic logic [6:0] nibble_hundredths(input logic [3:0] nib);
    logic [8:0] prod;
    prod = {5'd0, nib} * 9'd25;
    return prod[8:2];
  endfunction

endpackage

// ===== src/owts_in_if.sv =====
interface owts_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [2:0] sensor_select;
  logic [7:0] pin_levels;

  modport source (output valid, output start_req, output sensor_select, output pin_levels,
                  input ready);
  modport sink (input valid, input start_req, input sensor_select, input pin_levels,
                output ready);
endinterface

// ===== src/owts_out_if.sv =====
interface owts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_mask;
  logic       busy_res;
  logic       done_res;
  logic [6:0] whole_degrees;
  logic [6:0] hundredths;

  modport source (output valid, output drive_mask, output busy_res, output done_res,
                  output whole_degrees, output hundredths, input ready);
  modport sink (input valid, input drive_mask, input busy_res, input done_res,
                input whole_degrees, input hundredths, output ready);
endinterface

// ===== src/onewire_temp_sensor_master.sv =====
// 1-wire temperature sensor master, stepped once per microsecond tick.
// in_ch carries one word per tick: start request, sensor line select and
// the sampled pin levels (which reflect the drive mask of the previous tick).
// out_ch returns one word per input word: the pull-low mask, busy, a one-tick
// done flag and the last reading as whole degrees and hundredths.
// cfg_we / cfg_index / cfg_data write the seven timing registers (in ticks);
// a register holding zero counts as one tick.
// Latency: the result word for a tick is valid the cycle after it is taken.
// Throughput: one tick per clock cycle while out_ch does not stall; the
// sequencer and the result register each advance once per accepted word.
// A stalled receiver holds the result word; in_ch.ready stays high while the
// result register is empty or being drained in the same cycle, so ticks keep
// flowing without a gap.
// Reset: sequencer idle, timings at their defaults, reading zero, no word
// pending on out_ch.
module onewire_temp_sensor_master
  import owts_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  owts_in_if.sink              in_ch,
  owts_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [9:0] reset_low_us, presence_wait_us, reset_recover_us;
  logic [3:0] slot_start_us;
  logic [9:0] write_slot_us, read_sample_us, read_recover_us;

  logic               busy, busy_next;
  stage_t             stage, stage_next;
  sub_t               sub, sub_next;
  logic [TIMER_W-1:0] tick_timer, tick_timer_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [7:0]         raw_low, raw_low_next;
  logic [7:0]         raw_high, raw_high_next;
  logic [2:0]         line_index, line_index_next;
  logic [6:0]         whole_reg, whole_reg_next;
  logic [6:0]         fraction_reg, fraction_reg_next;

  logic       out_valid;
  logic [7:0] drive_mask;
  logic       busy_res, done_res;
  logic [7:0] drive_next;
  logic       done_next;

  logic       accept;
  kind_t      kind;
  logic [9:0] dur_raw, dur;
  logic [TIMER_W:0] timer_inc;
  logic       sample_bit;
  logic [PIN_COUNT-1:0] line_mask;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid;
  assign out_ch.drive_mask    = drive_mask;
  assign out_ch.busy_res      = busy_res;
  assign out_ch.done_res      = done_res;
  assign out_ch.whole_degrees = whole_reg;
  assign out_ch.hundredths    = fraction_reg;

  assign kind       = stage_kind(stage);
  assign timer_inc  = {1'b0, tick_timer} + 11'd1;
  assign sample_bit = in_ch.pin_levels[line_index];

  always_comb begin
    dur_raw = 10'd0;
    unique case (kind)
      KIND_RESET: begin
        if (sub == SUB_OPEN) begin
          dur_raw = reset_low_us;
        end else if (sub == SUB_MIDDLE) begin
          dur_raw = presence_wait_us;
        end else begin
          dur_raw = reset_recover_us;
        end
      end
      KIND_WRITE: begin
        dur_raw = (sub == SUB_OPEN) ? {6'd0, slot_start_us} : write_slot_us;
      end
      default: begin
        if (sub == SUB_OPEN) begin
          dur_raw = {6'd0, slot_start_us};
        end else if (sub == SUB_MIDDLE) begin
          dur_raw = read_sample_us;
        end else begin
          dur_raw = read_recover_us;
        end
      end
    endcase
    dur = (dur_raw == 10'd0) ? 10'd1 : dur_raw;
  end

  always_comb begin
    busy_next         = busy;
    stage_next        = stage;
    sub_next          = sub;
    tick_timer_next   = tick_timer;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    raw_low_next      = raw_low;
    raw_high_next     = raw_high;
    line_index_next   = line_index;
    whole_reg_next    = whole_reg;
    fraction_reg_next = fraction_reg;
    done_next         = 1'b0;

    if (!busy) begin
      if (in_ch.start_req && ({29'd0, in_ch.sensor_select} < 32'(PIN_COUNT))) begin
        line_index_next = in_ch.sensor_select;
        busy_next       = 1'b1;
        stage_next      = STG_RESET_CONV;
        sub_next        = SUB_OPEN;
        tick_timer_next = '0;
        bit_index_next  = 3'd0;
        shift_byte_next = stage_cmd(STG_RESET_CONV);
      end
    end else if (timer_inc < {1'b0, dur}) begin
      tick_timer_next = timer_inc[TIMER_W-1:0];
    end else begin
      logic   enter;
      stage_t next_stage;
      enter           = 1'b0;
      next_stage      = stage_t'(stage + 4'd1);
      tick_timer_next = '0;
      unique case (kind)
        KIND_RESET: begin
          if (sub == SUB_OPEN) begin
            sub_next = SUB_MIDDLE;
          end else if (sub == SUB_MIDDLE) begin
            sub_next = SUB_TAIL;
          end else if (stage == STG_RESET_LAST) begin
            whole_reg_next    = {raw_high[2:0], raw_low[7:4]};
            fraction_reg_next = nibble_hundredths(raw_low[3:0]);
            busy_next         = 1'b0;
            done_next         = 1'b1;
          end else begin
            enter = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (sub == SUB_OPEN) begin
            sub_next = SUB_MIDDLE;
          end else begin
            shift_byte_next = {1'b0, shift_byte[7:1]};
            if (bit_index == 3'd7) begin
              enter = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              sub_next       = SUB_OPEN;
            end
          end
        end
        default: begin
          if (sub == SUB_OPEN) begin
            sub_next = SUB_MIDDLE;
          end else if (sub == SUB_MIDDLE) begin
            shift_byte_next = {sample_bit, shift_byte[7:1]};
            sub_next        = SUB_TAIL;
          end else if (stage == STG_POLL) begin
            if (shift_byte[7]) begin
              enter = 1'b1;
            end else begin
              sub_next = SUB_OPEN;
            end
          end else if (bit_index == 3'd7) begin
            if (stage == STG_READ_LOW) begin
              raw_low_next = shift_byte;
            end else begin
              raw_high_next = shift_byte;
            end
            enter = 1'b1;
          end else begin
            bit_index_next = bit_index + 3'd1;
            sub_next       = SUB_OPEN;
          end
        end
      endcase
      if (enter) begin
        stage_next      = next_stage;
        sub_next        = SUB_OPEN;
        bit_index_next  = 3'd0;
        shift_byte_next = stage_cmd(next_stage);
      end
    end

    line_mask  = PIN_COUNT'(1) << line_index_next;
    drive_next = 8'd0;
    if (busy_next) begin
      if (sub_next == SUB_OPEN ||
          (stage_kind(stage_next) == KIND_WRITE && sub_next == SUB_MIDDLE &&
           !shift_byte_next[0])) begin
        drive_next = 8'(line_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us     <= 10'd480;
      presence_wait_us <= 10'd60;
      reset_recover_us <= 10'd420;
      slot_start_us    <= 4'd1;
      write_slot_us    <= 10'd60;
      read_sample_us   <= 10'd14;
      read_recover_us  <= 10'd45;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     reset_low_us     <= cfg_data;
        REG_PRESENCE_WAIT: presence_wait_us <= cfg_data;
        REG_RESET_RECOVER: reset_recover_us <= cfg_data;
        REG_SLOT_START:    slot_start_us    <= cfg_data[3:0];
        REG_WRITE_SLOT:    write_slot_us    <= cfg_data;
        REG_READ_SAMPLE:   read_sample_us   <= cfg_data;
        REG_READ_RECOVER:  read_recover_us  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      stage        <= STG_RESET_CONV;
      sub          <= SUB_OPEN;
      tick_timer   <= '0;
      bit_index    <= 3'd0;
      shift_byte   <= 8'd0;
      raw_low      <= 8'd0;
      raw_high     <= 8'd0;
      line_index   <= 3'd0;
      whole_reg    <= 7'd0;
      fraction_reg <= 7'd0;
      out_valid    <= 1'b0;
      drive_mask   <= 8'd0;
      busy_res     <= 1'b0;
      done_res     <= 1'b0;
    end else begin
      if (accept) begin
        busy         <= busy_next;
        stage        <= stage_next;
        sub          <= sub_next;
        tick_timer   <= tick_timer_next;
        bit_index    <= bit_index_next;
        shift_byte   <= shift_byte_next;
        raw_low      <= raw_low_next;
        raw_high     <= raw_high_next;
        line_index   <= line_index_next;
        whole_reg    <= whole_reg_next;
        fraction_reg <= fraction_reg_next;
        drive_mask   <= drive_next;
        busy_res     <= busy_next;
        done_res     <= done_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
